FILE: src/lfna_pkg.sv
// shared types, codes and helpers for the lowest free number allocator
package lfna_pkg;

	localparam int MAX_VALUE_DEF = 1024;
	localparam int NUM_W = 11;
	localparam int STATUS_W = 3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_POPPED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ADDED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

	// item classes decided at the front
	localparam logic [1:0] K_POP = 2'd0;
	localparam logic [1:0] K_ADD = 2'd1;
	localparam logic [1:0] K_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [NUM_W-1:0] number;
	} lfna_item_t;

	// index of the lowest set bit of a 32-bit word, 0 when none
	function automatic logic [4:0] ffs32(input logic [31:0] w);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (w[i]) begin
				r = 5'(i);
			end
		end
		return r;
	endfunction

endpackage

FILE: src/lfna_front.sv
// input side: accepts items, classifies them and queues them for the search engine
module lfna_front #(
	parameter int MAX_VALUE = lfna_pkg::MAX_VALUE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic [lfna_pkg::NUM_W-1:0] number_in,
	output logic item_valid,
	input  logic item_ready,
	output lfna_pkg::lfna_item_t item
);

	lfna_pkg::lfna_item_t queue_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	lfna_pkg::lfna_item_t cls;
	logic push;
	logic pop;

	always_comb begin
		cls.number = number_in;
		if (!operation) begin
			cls.kind = lfna_pkg::K_POP;
		end else if (number_in == '0 || 32'(number_in) > MAX_VALUE) begin
			cls.kind = lfna_pkg::K_RANGE;
		end else begin
			cls.kind = lfna_pkg::K_ADD;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item = queue_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/lfna_back.sv
// search engine: two-level presence map in memories with a flop top level, plus result register
module lfna_back #(
	parameter int MAX_VALUE = lfna_pkg::MAX_VALUE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  lfna_pkg::lfna_item_t item,
	output logic out_valid,
	input  logic out_ready,
	output logic [lfna_pkg::NUM_W-1:0] number_out,
	output logic [lfna_pkg::STATUS_W-1:0] status
);

	localparam int R = (MAX_VALUE + 31) / 32;
	localparam int R2 = (R + 31) / 32;
	localparam int RW = (R > 1) ? $clog2(R) : 1;
	localparam int SW = (R2 > 1) ? $clog2(R2) : 1;
	localparam int TW = $clog2(R + 1);
	localparam int TSW = $clog2(R2 + 1);
	localparam int IW = $clog2(MAX_VALUE);
	localparam int IXW = (IW < 10) ? 10 : IW;
	localparam int LCNT = MAX_VALUE - (R - 1) * 32;
	localparam int SCNT = R - (R2 - 1) * 32;
	localparam logic [31:0] LMASK = 32'((64'd1 << LCNT) - 64'd1);
	localparam logic [31:0] SMASK = 32'((64'd1 << SCNT) - 64'd1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SUM = 2'd1;
	localparam logic [1:0] S_LEAF = 2'd2;
	localparam logic [1:0] S_ADD = 2'd3;

	logic [31:0] leaf_mem [R];
	logic [31:0] sum_mem [R2];
	logic [31:0] leaf_rd_q;
	logic [31:0] sum_rd_q;

	logic [1:0] st_q;
	logic [R2-1:0] top_q;
	logic [TW-1:0] t_q;
	logic [TSW-1:0] ts_q;
	logic [RW-1:0] r_q;
	logic [SW-1:0] s_q;
	logic [4:0] b_q;
	logic [4:0] sb_q;
	logic ltouch_q;
	logic stouch_q;
	logic [31:0] sdata_q;
	logic [lfna_pkg::NUM_W-1:0] num_q;

	logic out_valid_q;
	logic [lfna_pkg::NUM_W-1:0] number_q;
	logic [lfna_pkg::STATUS_W-1:0] status_q;

	logic [RW-1:0] leaf_ra;
	logic [SW-1:0] sum_ra;
	logic leaf_we;
	logic sum_we;
	logic [RW-1:0] leaf_wa;
	logic [SW-1:0] sum_wa;
	logic [31:0] leaf_wd;
	logic [31:0] sum_wd;

	logic [SW-1:0] top_first;
	logic top_any;
	logic take;
	logic [IXW-1:0] add_idx;
	logic [IXW-1:0] pidx_sum;
	logic [IXW-1:0] pidx_leaf;
	logic [IXW:0] pop_num;
	logic [31:0] sdata;
	logic [31:0] ldata;
	logic [4:0] sb;
	logic [4:0] lb;
	logic [31:0] new_leaf;
	logic [31:0] new_sum;
	logic [31:0] add_leaf;
	logic [31:0] add_sum;

	// lowest summary word that still has a present number
	always_comb begin
		top_first = '0;
		for (int i = R2 - 1; i >= 0; i--) begin
			if (top_q[i]) begin
				top_first = SW'(i);
			end
		end
	end
	assign top_any = |top_q;

	assign item_ready = (st_q == S_IDLE) && (!out_valid_q || out_ready);
	assign take = item_valid && item_ready;
	assign add_idx = IXW'(item.number - lfna_pkg::NUM_W'(1));

	// untouched rows read as all present within range
	assign sdata = stouch_q ? sum_rd_q : ((s_q == SW'(R2 - 1)) ? SMASK : '1);
	assign ldata = ltouch_q ? leaf_rd_q : ((r_q == RW'(R - 1)) ? LMASK : '1);
	assign sb = lfna_pkg::ffs32(sdata);
	assign lb = lfna_pkg::ffs32(ldata);
	assign pidx_sum = (IXW'(s_q) << 10) | (IXW'(sb) << 5);
	assign pidx_leaf = (IXW'(r_q) << 5) | IXW'(lb);
	assign pop_num = {1'b0, pidx_leaf} + (IXW + 1)'(1);
	assign new_leaf = ldata & ~(32'd1 << lb);
	assign new_sum = sdata_q & ~(32'd1 << sb_q);
	assign add_leaf = ldata | (32'd1 << b_q);
	assign add_sum = sdata | (32'd1 << sb_q);

	always_comb begin
		leaf_ra = r_q;
		sum_ra = s_q;
		leaf_we = 1'b0;
		sum_we = 1'b0;
		leaf_wa = r_q;
		sum_wa = s_q;
		leaf_wd = new_leaf;
		sum_wd = new_sum;
		unique case (st_q)
			S_IDLE: begin
				if (item.kind == lfna_pkg::K_ADD) begin
					leaf_ra = RW'(add_idx >> 5);
					sum_ra = SW'(add_idx >> 10);
				end else begin
					sum_ra = top_first;
				end
			end
			S_SUM: begin
				leaf_ra = RW'(pidx_sum >> 5);
			end
			S_LEAF: begin
				leaf_we = 1'b1;
				sum_we = (new_leaf == '0);
			end
			S_ADD: begin
				leaf_wd = add_leaf;
				sum_wd = add_sum;
				leaf_we = !ldata[b_q];
				sum_we = !ldata[b_q] && !sdata[sb_q];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (leaf_we) begin
			leaf_mem[leaf_wa] <= leaf_wd;
		end
		leaf_rd_q <= leaf_mem[leaf_ra];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wa] <= sum_wd;
		end
		sum_rd_q <= sum_mem[sum_ra];
	end

	// working registers of the item in flight
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				num_q <= item.number;
				if (item.kind == lfna_pkg::K_ADD) begin
					r_q <= RW'(add_idx >> 5);
					s_q <= SW'(add_idx >> 10);
					b_q <= add_idx[4:0];
					sb_q <= add_idx[9:5];
					ltouch_q <= (TW'(RW'(add_idx >> 5)) < t_q);
					stouch_q <= (TSW'(SW'(add_idx >> 10)) < ts_q);
				end else begin
					s_q <= top_first;
					stouch_q <= (TSW'(top_first) < ts_q);
				end
			end
			S_SUM: begin
				r_q <= RW'(pidx_sum >> 5);
				sb_q <= sb;
				sdata_q <= sdata;
				ltouch_q <= (TW'(RW'(pidx_sum >> 5)) < t_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			top_q <= '1;
			t_q <= '0;
			ts_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (take) begin
						unique case (item.kind)
							lfna_pkg::K_POP: begin
								if (top_any) begin
									st_q <= S_SUM;
								end else begin
									out_valid_q <= 1'b1;
									number_q <= '0;
									status_q <= lfna_pkg::ST_EMPTY;
								end
							end
							lfna_pkg::K_ADD: begin
								st_q <= S_ADD;
							end
							default: begin
								out_valid_q <= 1'b1;
								number_q <= item.number;
								status_q <= lfna_pkg::ST_RANGE;
							end
						endcase
					end
				end
				S_SUM: begin
					st_q <= S_LEAF;
				end
				S_LEAF: begin
					st_q <= S_IDLE;
					// touched rows always form a prefix, so the count only steps by one
					if (TW'(r_q) >= t_q) begin
						t_q <= t_q + TW'(1);
					end
					if (new_leaf == '0) begin
						if (TSW'(s_q) >= ts_q) begin
							ts_q <= ts_q + TSW'(1);
						end
						if (new_sum == '0) begin
							top_q[s_q] <= 1'b0;
						end
					end
					out_valid_q <= 1'b1;
					number_q <= pop_num[lfna_pkg::NUM_W-1:0];
					status_q <= lfna_pkg::ST_POPPED;
				end
				S_ADD: begin
					st_q <= S_IDLE;
					out_valid_q <= 1'b1;
					number_q <= num_q;
					if (ldata[b_q]) begin
						status_q <= lfna_pkg::ST_PRESENT;
					end else begin
						top_q[s_q] <= 1'b1;
						status_q <= lfna_pkg::ST_ADDED;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign number_out = number_q;
	assign status = status_q;

endmodule

FILE: src/lowest_free_number_allocator.sv
// top level of the lowest free number allocator
// order: each item is registered into the queue; empty pops and out-of-range items then go
// straight to the result register, an add passes S_ADD and a pop S_SUM, which reads a summary
// word, then S_LEAF, which reads a leaf word; a new item is taken only when the engine is idle
// reset: every number 1..MAX_VALUE present at once; untouched map rows are tracked by fill
// counts, so no clearing pass is needed and the first item is accepted right after reset
module lowest_free_number_allocator #(
	parameter int MAX_VALUE = lfna_pkg::MAX_VALUE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic [lfna_pkg::NUM_W-1:0] number_in,
	output logic out_valid,
	input  logic out_ready,
	output logic [lfna_pkg::NUM_W-1:0] number_out,
	output logic [lfna_pkg::STATUS_W-1:0] status
);

	logic item_valid;
	logic item_ready;
	lfna_pkg::lfna_item_t item;

	lfna_front #(
		.MAX_VALUE(MAX_VALUE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.number_in(number_in),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item)
	);

	lfna_back #(
		.MAX_VALUE(MAX_VALUE)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.number_out(number_out),
		.status(status)
	);

endmodule
